/* src/luh_tpl_pkg.sv */
// Shared types and constants for the target position list parser.
package luh_tpl_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [2:0] REG_LIST_POINTER  = 3'd0;
  localparam logic [2:0] REG_FILE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_MAX_TARGETS   = 3'd2;
  localparam logic [2:0] REG_MAX_NAME_LEN  = 3'd3;
  localparam logic [2:0] REG_MAX_POSITIONS = 3'd4;
  localparam logic [2:0] REG_MAX_POS_LEN   = 3'd5;

  localparam logic [1:0] KIND_TARGET_COUNT = 2'd0;
  localparam logic [1:0] KIND_TARGET_NAME  = 2'd1;
  localparam logic [1:0] KIND_POS_COUNT    = 2'd2;
  localparam logic [1:0] KIND_POS_NAME     = 2'd3;

  localparam logic [2:0] STATUS_OK            = 3'd0;
  localparam logic [2:0] STATUS_BAD_POINTER   = 3'd1;
  localparam logic [2:0] STATUS_MANY_TARGETS  = 3'd2;
  localparam logic [2:0] STATUS_NAME_LONG     = 3'd3;
  localparam logic [2:0] STATUS_MANY_POS      = 3'd4;
  localparam logic [2:0] STATUS_POS_NAME_LONG = 3'd5;

  localparam logic [1:0] BV_NONE = 2'd0;
  localparam logic [1:0] BV_ONE  = 2'd1;
  localparam logic [1:0] BV_TWO  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_TLEN,
    PH_TNAME,
    PH_PCNT,
    PH_PLEN,
    PH_PNAME
  } phase_t;

  typedef enum logic [1:0] {
    START_RUN,
    START_BAD,
    START_EMPTY
  } start_class_t;

  typedef struct packed {
    logic [30:0] list_pointer_words;
    logic [31:0] file_length_bytes;
    logic [15:0] max_targets;
    logic [15:0] max_name_length;
    logic [15:0] max_positions;
    logic [15:0] max_position_length;
  } cfg_t;

  typedef struct packed {
    logic [15:0]  word;
    logic         file_start;
    start_class_t start_class;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target_index;
    logic [15:0] position_index;
    logic [15:0] value;
    logic [1:0]  bytes_valid;
    logic        done_res;
    logic [2:0]  status;
  } result_t;

endpackage

/* src/luh_tpl_front.sv */
// Input side: accepts file words, classifies start words and queues them.
module luh_tpl_front (
  input  logic                   clk,
  input  logic                   rst,
  input  luh_tpl_pkg::cfg_t      cfg,
  input  logic                   push,
  output logic                   full,
  input  logic [15:0]            word,
  input  logic                   file_start,
  output logic                   tok_valid,
  output luh_tpl_pkg::token_t    tok,
  input  logic                   tok_pop
);

  luh_tpl_pkg::token_t                      q [luh_tpl_pkg::QUEUE_DEPTH];
  logic [luh_tpl_pkg::CNT_W-1:0]            count;
  logic [luh_tpl_pkg::PTR_W-1:0]            wr_ptr;
  logic [luh_tpl_pkg::PTR_W-1:0]            rd_ptr;
  luh_tpl_pkg::token_t                      tok_in;
  logic                                     push_ok;
  logic                                     pop_ok;

  always_comb begin
    tok_in.word = word;
    tok_in.file_start = file_start;
    if ({cfg.list_pointer_words, 1'b0} > cfg.file_length_bytes) begin
      tok_in.start_class = luh_tpl_pkg::START_BAD;
    end else if (cfg.list_pointer_words == 31'd0) begin
      tok_in.start_class = luh_tpl_pkg::START_EMPTY;
    end else begin
      tok_in.start_class = luh_tpl_pkg::START_RUN;
    end
  end

  assign full = (count == luh_tpl_pkg::CNT_W'(luh_tpl_pkg::QUEUE_DEPTH));
  assign push_ok = push && !full;
  assign tok_valid = (count != '0);
  assign pop_ok = tok_pop && tok_valid;
  assign tok = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == luh_tpl_pkg::PTR_W'(luh_tpl_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == luh_tpl_pkg::PTR_W'(luh_tpl_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      count <= count + luh_tpl_pkg::CNT_W'(push_ok) - luh_tpl_pkg::CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= tok_in;
    end
  end

endmodule

/* src/luh_tpl_back.sv */
// Parse side: walks the target list and queues the results.
module luh_tpl_back (
  input  logic                   clk,
  input  logic                   rst,
  input  luh_tpl_pkg::cfg_t      cfg,
  input  logic                   tok_valid,
  input  luh_tpl_pkg::token_t    tok,
  output logic                   tok_pop,
  output logic                   empty,
  input  logic                   pop,
  output luh_tpl_pkg::result_t   res
);

  luh_tpl_pkg::phase_t phase, phase_next;
  logic [30:0] word_counter, word_counter_next;
  logic [15:0] targets_total, targets_total_next;
  logic [15:0] target_number, target_number_next;
  logic [15:0] positions_total, positions_total_next;
  logic [15:0] position_number, position_number_next;
  logic [15:0] name_bytes_left, name_bytes_left_next;

  logic                 go;
  logic [15:0]          w;
  logic [30:0]          wc_inc;
  logic                 at_list;
  logic [15:0]          tn_inc;
  logic [15:0]          pn_inc;
  logic                 tgt_end;
  logic                 pos_end;
  logic [1:0]           bv;
  logic [15:0]          nbl_dec;
  logic                 res_push;
  luh_tpl_pkg::result_t res_in;

  luh_tpl_pkg::result_t                     q [luh_tpl_pkg::QUEUE_DEPTH];
  logic [luh_tpl_pkg::CNT_W-1:0]            count;
  logic [luh_tpl_pkg::PTR_W-1:0]            wr_ptr;
  logic [luh_tpl_pkg::PTR_W-1:0]            rd_ptr;
  logic                                     res_full;
  logic                                     pop_ok;

  assign res_full = (count == luh_tpl_pkg::CNT_W'(luh_tpl_pkg::QUEUE_DEPTH));
  assign go = tok_valid && !res_full;
  assign tok_pop = go;
  assign w = tok.word;
  assign wc_inc = word_counter + 31'd1;
  assign at_list = (wc_inc == cfg.list_pointer_words);
  assign tn_inc = target_number + 16'd1;
  assign pn_inc = position_number + 16'd1;
  assign tgt_end = (tn_inc >= targets_total);
  assign pos_end = (pn_inc >= positions_total);
  assign bv = (name_bytes_left >= 16'd2) ? luh_tpl_pkg::BV_TWO : luh_tpl_pkg::BV_ONE;
  assign nbl_dec = name_bytes_left - {14'd0, bv};

  always_comb begin
    phase_next = phase;
    if (go) begin
      if (tok.file_start) begin
        phase_next = (tok.start_class == luh_tpl_pkg::START_RUN) ?
                     luh_tpl_pkg::PH_SKIP : luh_tpl_pkg::PH_IDLE;
      end else begin
        case (phase)
          luh_tpl_pkg::PH_SKIP: begin
            if (at_list) begin
              if (w > cfg.max_targets || w == 16'd0) begin
                phase_next = luh_tpl_pkg::PH_IDLE;
              end else begin
                phase_next = luh_tpl_pkg::PH_TLEN;
              end
            end
          end
          luh_tpl_pkg::PH_TLEN: begin
            if (w > cfg.max_name_length) begin
              phase_next = luh_tpl_pkg::PH_IDLE;
            end else if (w == 16'd0) begin
              phase_next = luh_tpl_pkg::PH_PCNT;
            end else begin
              phase_next = luh_tpl_pkg::PH_TNAME;
            end
          end
          luh_tpl_pkg::PH_TNAME: begin
            if (nbl_dec == 16'd0) begin
              phase_next = luh_tpl_pkg::PH_PCNT;
            end
          end
          luh_tpl_pkg::PH_PCNT: begin
            if (w > cfg.max_positions) begin
              phase_next = luh_tpl_pkg::PH_IDLE;
            end else if (w == 16'd0) begin
              phase_next = tgt_end ? luh_tpl_pkg::PH_IDLE : luh_tpl_pkg::PH_TLEN;
            end else begin
              phase_next = luh_tpl_pkg::PH_PLEN;
            end
          end
          luh_tpl_pkg::PH_PLEN: begin
            if (w > cfg.max_position_length) begin
              phase_next = luh_tpl_pkg::PH_IDLE;
            end else if (w != 16'd0) begin
              phase_next = luh_tpl_pkg::PH_PNAME;
            end else if (!pos_end) begin
              phase_next = luh_tpl_pkg::PH_PLEN;
            end else begin
              phase_next = tgt_end ? luh_tpl_pkg::PH_IDLE : luh_tpl_pkg::PH_TLEN;
            end
          end
          luh_tpl_pkg::PH_PNAME: begin
            if (nbl_dec == 16'd0) begin
              if (!pos_end) begin
                phase_next = luh_tpl_pkg::PH_PLEN;
              end else begin
                phase_next = tgt_end ? luh_tpl_pkg::PH_IDLE : luh_tpl_pkg::PH_TLEN;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_comb begin
    word_counter_next = word_counter;
    targets_total_next = targets_total;
    target_number_next = target_number;
    positions_total_next = positions_total;
    position_number_next = position_number;
    name_bytes_left_next = name_bytes_left;
    res_push = 1'b0;
    res_in.kind = luh_tpl_pkg::KIND_TARGET_COUNT;
    res_in.target_index = target_number;
    res_in.position_index = 16'd0;
    res_in.value = w;
    res_in.bytes_valid = luh_tpl_pkg::BV_TWO;
    res_in.done_res = 1'b0;
    res_in.status = luh_tpl_pkg::STATUS_OK;
    if (go) begin
      if (tok.file_start) begin
        word_counter_next = '0;
        targets_total_next = '0;
        target_number_next = '0;
        positions_total_next = '0;
        position_number_next = '0;
        name_bytes_left_next = '0;
        res_push = (tok.start_class != luh_tpl_pkg::START_RUN);
        res_in.target_index = 16'd0;
        res_in.value = 16'd0;
        res_in.bytes_valid = luh_tpl_pkg::BV_NONE;
        res_in.done_res = 1'b1;
        res_in.status = (tok.start_class == luh_tpl_pkg::START_BAD) ?
                        luh_tpl_pkg::STATUS_BAD_POINTER : luh_tpl_pkg::STATUS_OK;
      end else begin
        case (phase)
          luh_tpl_pkg::PH_SKIP: begin
            word_counter_next = wc_inc;
            res_in.target_index = 16'd0;
            if (at_list) begin
              res_push = 1'b1;
              if (w > cfg.max_targets) begin
                res_in.done_res = 1'b1;
                res_in.status = luh_tpl_pkg::STATUS_MANY_TARGETS;
              end else begin
                targets_total_next = w;
                target_number_next = 16'd0;
                res_in.done_res = (w == 16'd0);
              end
            end
          end
          luh_tpl_pkg::PH_TLEN: begin
            if (w > cfg.max_name_length) begin
              res_push = 1'b1;
              res_in.kind = luh_tpl_pkg::KIND_TARGET_NAME;
              res_in.bytes_valid = luh_tpl_pkg::BV_NONE;
              res_in.done_res = 1'b1;
              res_in.status = luh_tpl_pkg::STATUS_NAME_LONG;
            end else begin
              name_bytes_left_next = w;
            end
          end
          luh_tpl_pkg::PH_TNAME: begin
            name_bytes_left_next = nbl_dec;
            res_push = 1'b1;
            res_in.kind = luh_tpl_pkg::KIND_TARGET_NAME;
            res_in.bytes_valid = bv;
          end
          luh_tpl_pkg::PH_PCNT: begin
            res_push = 1'b1;
            res_in.kind = luh_tpl_pkg::KIND_POS_COUNT;
            if (w > cfg.max_positions) begin
              res_in.done_res = 1'b1;
              res_in.status = luh_tpl_pkg::STATUS_MANY_POS;
            end else begin
              positions_total_next = w;
              position_number_next = 16'd0;
              if (w == 16'd0) begin
                target_number_next = tn_inc;
                res_in.done_res = tgt_end;
              end
            end
          end
          luh_tpl_pkg::PH_PLEN: begin
            res_in.kind = luh_tpl_pkg::KIND_POS_NAME;
            res_in.position_index = position_number;
            res_in.bytes_valid = luh_tpl_pkg::BV_NONE;
            if (w > cfg.max_position_length) begin
              res_push = 1'b1;
              res_in.done_res = 1'b1;
              res_in.status = luh_tpl_pkg::STATUS_POS_NAME_LONG;
            end else begin
              name_bytes_left_next = w;
              if (w == 16'd0) begin
                position_number_next = pn_inc;
                if (pos_end) begin
                  target_number_next = tn_inc;
                  res_push = tgt_end;
                  res_in.done_res = 1'b1;
                end
              end
            end
          end
          luh_tpl_pkg::PH_PNAME: begin
            name_bytes_left_next = nbl_dec;
            res_push = 1'b1;
            res_in.kind = luh_tpl_pkg::KIND_POS_NAME;
            res_in.position_index = position_number;
            res_in.bytes_valid = bv;
            if (nbl_dec == 16'd0) begin
              position_number_next = pn_inc;
              if (pos_end) begin
                target_number_next = tn_inc;
                res_in.done_res = tgt_end;
              end
            end
          end
          default: begin
            res_push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= luh_tpl_pkg::PH_IDLE;
      word_counter <= '0;
      targets_total <= '0;
      target_number <= '0;
      positions_total <= '0;
      position_number <= '0;
      name_bytes_left <= '0;
    end else begin
      phase <= phase_next;
      word_counter <= word_counter_next;
      targets_total <= targets_total_next;
      target_number <= target_number_next;
      positions_total <= positions_total_next;
      position_number <= position_number_next;
      name_bytes_left <= name_bytes_left_next;
    end
  end

  assign empty = (count == '0);
  assign pop_ok = pop && !empty;
  assign res = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= (wr_ptr == luh_tpl_pkg::PTR_W'(luh_tpl_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == luh_tpl_pkg::PTR_W'(luh_tpl_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      count <= count + luh_tpl_pkg::CNT_W'(res_push) - luh_tpl_pkg::CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res_in;
    end
  end

endmodule

/* src/luh_target_position_list_parser.sv */
// Top level of the target position list parser with its register file.
// A word is held in the input queue, then parsed into the result queue, whose head drives the ports.
// Throughput: one word per cycle; only a full result queue stalls the parse stage.
// Each word needs one pass through the parse state machine and no other unit.
// Reset clears the registers, both queues and the parse state; the block then waits
// for a word marked as a file start.
module luh_target_position_list_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] word,
  input  logic        file_start,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] target_index,
  output logic [15:0] position_index,
  output logic [15:0] value,
  output logic [1:0]  bytes_valid,
  output logic        done_res,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  luh_tpl_pkg::cfg_t    cfg;
  luh_tpl_pkg::token_t  tok;
  luh_tpl_pkg::result_t res;
  logic                 tok_valid;
  logic                 tok_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        luh_tpl_pkg::REG_LIST_POINTER:  cfg.list_pointer_words <= cfg_data[30:0];
        luh_tpl_pkg::REG_FILE_LENGTH:   cfg.file_length_bytes <= cfg_data;
        luh_tpl_pkg::REG_MAX_TARGETS:   cfg.max_targets <= cfg_data[15:0];
        luh_tpl_pkg::REG_MAX_NAME_LEN:  cfg.max_name_length <= cfg_data[15:0];
        luh_tpl_pkg::REG_MAX_POSITIONS: cfg.max_positions <= cfg_data[15:0];
        luh_tpl_pkg::REG_MAX_POS_LEN:   cfg.max_position_length <= cfg_data[15:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  luh_tpl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .word       (word),
    .file_start (file_start),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_pop    (tok_pop)
  );

  luh_tpl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign kind = res.kind;
  assign target_index = res.target_index;
  assign position_index = res.position_index;
  assign value = res.value;
  assign bytes_valid = res.bytes_valid;
  assign done_res = res.done_res;
  assign status = res.status;

endmodule
